// ===== src/pcbp_pkg.sv =====
// Package for the prefix code bit packer: beat payload structs, item kind codes
// and the code table entry layout. Used by the top level; no dependencies.
package pcbp_pkg;

  localparam int unsigned PatternBits = 32;
  localparam int unsigned LengthBits  = 6;
  localparam int unsigned EntryBits   = PatternBits + LengthBits;
  localparam int unsigned PendBits    = 7;
  localparam int unsigned AccBits     = PatternBits + PendBits;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindEncode = 2'd1;
  localparam logic [1:0] KindFlush  = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             symbol;
    logic [PatternBits-1:0] code_pattern;
    logic [LengthBits-1:0]  code_length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       final_byte;
  } out_beat_t;

  typedef struct packed {
    logic [LengthBits-1:0]  length;
    logic [PatternBits-1:0] pattern;
  } entry_t;

endpackage

// ===== src/pcbp_ram.sv =====
// Generic single-port RAM with a registered read port.
// No dependencies.
module pcbp_ram #(
  parameter int unsigned Width = 38,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/prefix_code_bit_packer_unit.sv =====
// Prefix code bit packer: code table in pcbp_ram, pending bit register and a
// byte drain register. Depends on pcbp_pkg and pcbp_ram.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   pcbp_pkg::in_beat_t
//   out      output     out_valid_o / out_stall_i pcbp_pkg::out_beat_t
//
// An item is accepted while in_stall_o is low; the table read is registered
// and the item merges with the pending bits in stage s1. Loads and items
// giving at most one byte run at one per cycle unless the output stalls. An
// n-byte encode holds the drain register until all n are out, stalling input.
// Reset clears the pending bits, the pipeline and the drain; the table needs
// no clearing.
module prefix_code_bit_packer_unit #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pcbp_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pcbp_pkg::out_beat_t  out_data_o
);

  import pcbp_pkg::*;

  localparam int unsigned AddrBits = $clog2(SYMBOL_COUNT);
  localparam int unsigned LenCap   = (MAX_CODE_LEN < PatternBits) ? MAX_CODE_LEN
                                                                  : PatternBits;

  logic in_acc, out_acc;
  logic sym_ok;
  logic [LengthBits-1:0] len_sat;
  entry_t wr_entry, rd_entry;

  logic                s1_valid_q, s1_valid_d;
  logic                s1_flush_q;
  logic                s1_symok_q;
  logic                s1_adv;
  logic [2:0]          s1_bytes;

  logic [PendBits-1:0] pend_q, pend_d;
  logic [2:0]          pcnt_q, pcnt_d;

  logic [PatternBits-1:0] drain_q, drain_d;
  logic [2:0]             dcnt_q, dcnt_d;
  logic                   dfin_q, dfin_d;
  logic                   drain_free;

  logic [LengthBits-1:0]  clen;
  logic [PatternBits:0]   len_mask;
  logic [PatternBits-1:0] cbits;
  logic [AccBits-1:0]     acc, acc_rest;
  logic [LengthBits-1:0]  cnt;

  assign sym_ok  = (32'(in_data_i.symbol) < SYMBOL_COUNT);
  assign len_sat = (in_data_i.code_length > LengthBits'(LenCap)) ? LengthBits'(LenCap)
                                                                : in_data_i.code_length;
  assign wr_entry.length  = len_sat;
  assign wr_entry.pattern = in_data_i.code_pattern;

  pcbp_ram #(
    .Width(EntryBits),
    .Depth(SYMBOL_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (in_acc && (in_data_i.kind == KindLoad) && sym_ok),
    .re_i   (in_acc && (in_data_i.kind == KindEncode)),
    .addr_i (AddrBits'(in_data_i.symbol)),
    .wdata_i(wr_entry),
    .rdata_o(rd_entry)
  );

  // Merge the looked-up code behind the pending bits.
  always_comb begin
    clen     = s1_symok_q ? rd_entry.length : '0;
    len_mask = ~({(PatternBits+1){1'b1}} << clen);
    cbits    = rd_entry.pattern & len_mask[PatternBits-1:0];
    acc      = AccBits'(pend_q) | (AccBits'(cbits) << pcnt_q);
    cnt      = LengthBits'(pcnt_q) + clen;
    acc_rest = acc >> {cnt[LengthBits-1:3], 3'b000};
  end

  assign s1_bytes   = s1_flush_q ? 3'd1 : cnt[LengthBits-1:3];
  assign drain_free = (dcnt_q == 3'd0) || ((dcnt_q == 3'd1) && out_acc);
  assign s1_adv     = s1_valid_q && ((s1_bytes == 3'd0) || drain_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = (in_data_i.kind == KindEncode) || (in_data_i.kind == KindFlush);
    end
  end

  always_comb begin
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    drain_d = drain_q;
    dcnt_d  = dcnt_q;
    dfin_d  = dfin_q;
    if (out_acc) begin
      drain_d = drain_q >> 8;
      dcnt_d  = dcnt_q - 3'd1;
    end
    if (s1_adv) begin
      if (s1_flush_q) begin
        pend_d  = '0;
        pcnt_d  = '0;
        drain_d = PatternBits'(pend_q);
        dcnt_d  = 3'd1;
        dfin_d  = 1'b1;
      end else begin
        pend_d = acc_rest[PendBits-1:0];
        pcnt_d = cnt[2:0];
        if (s1_bytes != 3'd0) begin
          drain_d = acc[PatternBits-1:0];
          dcnt_d  = s1_bytes;
          dfin_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= '0;
      pcnt_q     <= '0;
      dcnt_q     <= '0;
      dfin_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      pend_q     <= pend_d;
      pcnt_q     <= pcnt_d;
      dcnt_q     <= dcnt_d;
      dfin_q     <= dfin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drain_q <= drain_d;
    if (in_acc) begin
      s1_flush_q <= (in_data_i.kind == KindFlush);
      s1_symok_q <= sym_ok;
    end
  end

  assign out_valid_o           = (dcnt_q != 3'd0);
  assign out_data_o.out_byte   = drain_q[7:0];
  assign out_data_o.last       = (dcnt_q == 3'd1);
  assign out_data_o.final_byte = dfin_q;

endmodule
